/* design/lcho_pkg.sv */
package lcho_pkg;

  // grid defaults
  localparam int unsigned GRID_X_DEF   = 320;
  localparam int unsigned GRID_Y_DEF   = 160;
  localparam int unsigned CELL_CM_DEF  = 25;
  localparam int unsigned COL_BIAS_DEF = 80;
  localparam int unsigned ROW_BIAS_DEF = 80;

  // field widths
  localparam int unsigned COORD_W  = 16;
  localparam int unsigned HGT_W    = 14;
  localparam int unsigned CNT_W    = 16;
  localparam int unsigned SUM_W    = 30;
  localparam int unsigned SQ_W     = 42;
  localparam int unsigned ROUGH_W  = 20;
  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned CFG_DAT_W = 20;

  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  // operation codes
  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_READ = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_LOW  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_HIGH = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VEH_LEFT    = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_VEH_RIGHT   = 4'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_VEH_FRONT   = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_VEH_BACK    = 4'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SPAN_THR    = 4'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_ROUGH_THR   = 4'd7;

  // one cell record as held in the cell memory
  typedef struct packed {
    logic        [CNT_W-1:0] count;
    logic signed [SUM_W-1:0] sum;
    logic        [SQ_W-1:0]  sum_sq;
    logic signed [HGT_W-1:0] low;
    logic signed [HGT_W-1:0] high;
  } cell_t;

endpackage

/* design/lcho_if.sv */
interface lcho_in_if;
  logic               valid;
  logic               ready;
  logic               operation;
  logic signed [15:0] x_cm;
  logic signed [15:0] y_cm;
  logic signed [15:0] z_cm;
  logic        [8:0]  cell_col;
  logic        [7:0]  cell_row;

  modport source (output valid, operation, x_cm, y_cm, z_cm, cell_col, cell_row,
                  input ready);
  modport sink (input valid, operation, x_cm, y_cm, z_cm, cell_col, cell_row,
                output ready);
endinterface

interface lcho_out_if;
  logic               valid;
  logic               ready;
  logic               accepted;
  logic               obstacle;
  logic        [15:0] point_count;
  logic signed [13:0] height_min;
  logic signed [13:0] height_max;

  modport source (output valid, accepted, obstacle, point_count, height_min, height_max,
                  input ready);
  modport sink (input valid, accepted, obstacle, point_count, height_min, height_max,
                output ready);
endinterface

/* design/lcho_ram.sv */
module lcho_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                 wdata_i,
  input  logic                             re_i,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr_i,
  output logic [WIDTH-1:0]                 rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end
endmodule

/* design/lidar_cell_height_obstacle_grid.sv */
// channel   | dir | handshake       | payload
// item_in   | in  | valid / ready   | operation, x_cm, y_cm, z_cm, cell_col, cell_row
// res_out   | out | valid / ready   | accepted, obstacle, point_count, height_min, height_max
// cfg       | in  | cfg_we_i only   | cfg_idx_i, cfg_data_i
//
// one item at a time: a binned point passes CALC, ADDR, RD and MOD to the result register,
// a read of a non-empty cell CALC, RD, MOD, E1, E2 and E3, an empty cell read CALC, RD and
// MOD, a point binned outside the grid CALC and ADDR, a point dropped by the filters or an
// out-of-grid read CALC alone; the path is set by the read-modify-write of the single cell memory
// after reset a clearing pass writes every cell to zero with item_in not ready;
// config writes are taken at any time
// a result waits in the output register while the next item is taken; the
// sequencer stalls in its last state until the output register is free
module lidar_cell_height_obstacle_grid #(
  parameter int unsigned GRID_X   = lcho_pkg::GRID_X_DEF,
  parameter int unsigned GRID_Y   = lcho_pkg::GRID_Y_DEF,
  parameter int unsigned CELL_CM  = lcho_pkg::CELL_CM_DEF,
  parameter int unsigned COL_BIAS = lcho_pkg::COL_BIAS_DEF,
  parameter int unsigned ROW_BIAS = lcho_pkg::ROW_BIAS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [lcho_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [lcho_pkg::CFG_DAT_W-1:0]  cfg_data_i,
  lcho_in_if.sink                         item_in,
  lcho_out_if.source                      res_out
);
  import lcho_pkg::*;

  localparam int unsigned NCELLS = GRID_X * GRID_Y;
  localparam int unsigned AW     = $clog2(NCELLS > 1 ? NCELLS : 2);
  localparam int unsigned CELL_W = $bits(cell_t);

  // round(|v|/CELL_CM) = floor((2|v| + CELL_CM) / (2*CELL_CM)) by reciprocal
  localparam int unsigned DIV_D  = 2 * CELL_CM;
  localparam int unsigned NUM_W  = 17;
  localparam int unsigned SH     = NUM_W + $clog2(DIV_D);
  localparam int unsigned PROD_W = NUM_W + SH + 1;
  localparam longint unsigned RECIP_L = ((64'd1 << SH) + 64'(DIV_D) - 64'd1) / 64'(DIV_D);
  localparam logic [SH:0] RECIP = RECIP_L[SH:0];
  localparam int unsigned Q_W    = 16;
  localparam int unsigned IDX_W  = 18;
  localparam int unsigned LHS_W  = 61;
  localparam int unsigned SQ_LO  = 21;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_CALC, S_ADDR, S_RD, S_MOD, S_E1, S_E2, S_E3, S_DONE
  } state_e;

  state_e state_q;
  logic [AW-1:0] clr_addr_q;
  logic          out_vld_q;

  // config registers
  logic signed [HGT_W-1:0] hlow_q, hhigh_q, vleft_q, vright_q, vfront_q, vback_q;
  logic [HGT_W-1:0]        span_thr_q;
  logic [ROUGH_W-1:0]      rough_thr_q;

  // item registers
  logic                     op_q;
  logic signed [COORD_W-1:0] x_q, y_q, z_q;
  logic [8:0]               col_q;
  logic [7:0]               row_q;

  // working registers
  logic [Q_W-1:0]  qx_q, qy_q;
  logic            sx_q, sy_q;
  logic            keep_q;
  logic            cell_ok_q;
  logic [26:0]     zsq_q;
  logic [AW-1:0]   addr_q;
  cell_t           cell_q;
  logic [36:0]     plo_q, phi_q;
  logic [59:0]     ss_q;
  logic [35:0]     tn_q;
  logic [LHS_W-1:0] lhs_q;
  logic [51:0]     tnn_q;
  logic            span_ok_q;

  // pending result and output registers
  logic                    res_acc_q, res_obs_q;
  logic [CNT_W-1:0]        res_cnt_q;
  logic signed [HGT_W-1:0] res_lo_q, res_hi_q;
  logic                    o_acc_q, o_obs_q;
  logic [CNT_W-1:0]        o_cnt_q;
  logic signed [HGT_W-1:0] o_lo_q, o_hi_q;

  // memory port
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr;
  cell_t         ram_wdata, ram_rdata, cell_upd;

  // combinational helpers
  logic [NUM_W-1:0]   ax, ay, numx, numy;
  logic [PROD_W-1:0]  prodx, prody;
  logic signed [COORD_W-1:0] lo16, hi16, vl16, vr16, vf16, vb16;
  logic               in_win, in_box;
  logic signed [IDX_W-1:0] xi, yi;
  logic               xi_ok, yi_ok;
  logic [AW-1:0]      add_addr, rd_addr;
  logic signed [COORD_W-1:0] span_diff;
  logic [SUM_W-1:0]   sabs;
  logic [LHS_W-1:0]   rhs;
  logic               out_free;

  assign item_in.ready = (state_q == S_IDLE);
  assign out_free      = !out_vld_q || res_out.ready;

  assign res_out.valid       = out_vld_q;
  assign res_out.accepted    = o_acc_q;
  assign res_out.obstacle    = o_obs_q;
  assign res_out.point_count = o_cnt_q;
  assign res_out.height_min  = o_lo_q;
  assign res_out.height_max  = o_hi_q;

  // filters and binning on the latched point
  always_comb begin
    lo16 = COORD_W'(hlow_q);
    hi16 = COORD_W'(hhigh_q);
    vl16 = COORD_W'(vleft_q);
    vr16 = COORD_W'(vright_q);
    vf16 = COORD_W'(vfront_q);
    vb16 = COORD_W'(vback_q);
    in_win = (z_q >= lo16) && (z_q <= hi16);
    in_box = (y_q > vr16) && (y_q < vl16) && (x_q > vb16) && (x_q < vf16);
    ax = x_q[COORD_W-1] ? NUM_W'(-{x_q[COORD_W-1], x_q}) : NUM_W'({1'b0, x_q});
    ay = y_q[COORD_W-1] ? NUM_W'(-{y_q[COORD_W-1], y_q}) : NUM_W'({1'b0, y_q});
    numx = NUM_W'({ax, 1'b0}) + NUM_W'(CELL_CM);
    numy = NUM_W'({ay, 1'b0}) + NUM_W'(CELL_CM);
    prodx = PROD_W'(numx) * PROD_W'(RECIP);
    prody = PROD_W'(numy) * PROD_W'(RECIP);
    rd_addr = AW'(AW'(col_q) * AW'(GRID_Y) + AW'(row_q));
  end

  // signed cell index and address
  always_comb begin
    xi = (sx_q ? -$signed(IDX_W'(qx_q)) : $signed(IDX_W'(qx_q))) + $signed(IDX_W'(COL_BIAS));
    yi = (sy_q ? -$signed(IDX_W'(qy_q)) : $signed(IDX_W'(qy_q))) + $signed(IDX_W'(ROW_BIAS));
    xi_ok = !xi[IDX_W-1] && (xi < $signed(IDX_W'(GRID_X)));
    yi_ok = !yi[IDX_W-1] && (yi < $signed(IDX_W'(GRID_Y)));
    add_addr = AW'(AW'(xi) * AW'(GRID_Y) + AW'(yi));
  end

  // cell update for an add
  always_comb begin
    cell_upd = ram_rdata;
    if (ram_rdata.count == '0) begin
      cell_upd.low  = z_q[HGT_W-1:0];
      cell_upd.high = z_q[HGT_W-1:0];
    end else begin
      if ($signed(z_q) < COORD_W'(ram_rdata.low)) begin
        cell_upd.low = z_q[HGT_W-1:0];
      end
      if ($signed(z_q) > COORD_W'(ram_rdata.high)) begin
        cell_upd.high = z_q[HGT_W-1:0];
      end
    end
    if (ram_rdata.count != COUNT_MAX) begin
      cell_upd.count  = ram_rdata.count + CNT_W'(1);
      cell_upd.sum    = ram_rdata.sum + SUM_W'(z_q);
      cell_upd.sum_sq = ram_rdata.sum_sq + SQ_W'(zsq_q);
    end
  end

  always_comb begin
    span_diff = COORD_W'(cell_q.high) - COORD_W'(cell_q.low);
    sabs = cell_q.sum[SUM_W-1] ? SUM_W'(-cell_q.sum) : SUM_W'(cell_q.sum);
    rhs = LHS_W'(ss_q) + LHS_W'(tnn_q);
  end

  // memory port control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr_q;
    ram_wdata = '0;
    ram_re    = (state_q == S_RD);
    if (state_q == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_q;
    end else if (state_q == S_MOD) begin
      ram_we = 1'b1;
      if (op_q == OP_ADD) begin
        ram_wdata = cell_upd;
      end
    end
  end

  lcho_ram #(
    .WIDTH (CELL_W),
    .DEPTH (NCELLS)
  ) u_cells (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (addr_q),
    .rdata_o (ram_rdata)
  );

  // config writes, unknown indexes ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hlow_q      <= -HGT_W'(200);
      hhigh_q     <= HGT_W'(100);
      vleft_q     <= HGT_W'(50);
      vright_q    <= -HGT_W'(50);
      vfront_q    <= HGT_W'(10);
      vback_q     <= -HGT_W'(120);
      span_thr_q  <= HGT_W'(15);
      rough_thr_q <= ROUGH_W'(20);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_HEIGHT_LOW:  hlow_q      <= cfg_data_i[HGT_W-1:0];
        CFG_HEIGHT_HIGH: hhigh_q     <= cfg_data_i[HGT_W-1:0];
        CFG_VEH_LEFT:    vleft_q     <= cfg_data_i[HGT_W-1:0];
        CFG_VEH_RIGHT:   vright_q    <= cfg_data_i[HGT_W-1:0];
        CFG_VEH_FRONT:   vfront_q    <= cfg_data_i[HGT_W-1:0];
        CFG_VEH_BACK:    vback_q     <= cfg_data_i[HGT_W-1:0];
        CFG_SPAN_THR:    span_thr_q  <= cfg_data_i[HGT_W-1:0];
        CFG_ROUGH_THR:   rough_thr_q <= cfg_data_i[ROUGH_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      clr_addr_q <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      if (state_q == S_DONE && out_free) begin
        out_vld_q <= 1'b1;
      end else if (res_out.ready) begin
        out_vld_q <= 1'b0;
      end
      unique case (state_q)
        S_CLEAR: begin
          clr_addr_q <= clr_addr_q + AW'(1);
          if (clr_addr_q == AW'(NCELLS - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (item_in.valid) begin
            state_q <= S_CALC;
          end
        end
        S_CALC: begin
          if (op_q == OP_READ) begin
            state_q <= (11'(col_q) < 11'(GRID_X) && 11'(row_q) < 11'(GRID_Y)) ? S_RD : S_DONE;
          end else begin
            state_q <= (in_win && !in_box) ? S_ADDR : S_DONE;
          end
        end
        S_ADDR:  state_q <= (xi_ok && yi_ok) ? S_RD : S_DONE;
        S_RD:    state_q <= S_MOD;
        S_MOD: begin
          state_q <= (op_q == OP_READ && ram_rdata.count != '0) ? S_E1 : S_DONE;
        end
        S_E1:    state_q <= S_E2;
        S_E2:    state_q <= S_E3;
        S_E3:    state_q <= S_DONE;
        S_DONE: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        op_q  <= item_in.operation;
        x_q   <= item_in.x_cm;
        y_q   <= item_in.y_cm;
        z_q   <= item_in.z_cm;
        col_q <= item_in.cell_col;
        row_q <= item_in.cell_row;
        res_acc_q <= 1'b0;
        res_obs_q <= 1'b0;
        res_cnt_q <= '0;
        res_lo_q  <= '0;
        res_hi_q  <= '0;
      end
      S_CALC: begin
        qx_q   <= prodx[SH +: Q_W];
        qy_q   <= prody[SH +: Q_W];
        sx_q   <= x_q[COORD_W-1];
        sy_q   <= y_q[COORD_W-1];
        keep_q <= in_win && !in_box;
        zsq_q  <= 27'(32'(z_q) * 32'(z_q));
        addr_q <= rd_addr;
      end
      S_ADDR: begin
        addr_q    <= add_addr;
        cell_ok_q <= xi_ok && yi_ok;
      end
      S_MOD: begin
        cell_q <= ram_rdata;
        if (op_q == OP_ADD) begin
          res_acc_q <= 1'b1;
        end else if (ram_rdata.count != '0) begin
          res_cnt_q <= ram_rdata.count;
          res_lo_q  <= ram_rdata.low;
          res_hi_q  <= ram_rdata.high;
        end
      end
      S_E1: begin
        plo_q <= 37'(cell_q.count) * 37'(cell_q.sum_sq[SQ_LO-1:0]);
        phi_q <= 37'(cell_q.count) * 37'(cell_q.sum_sq[SQ_W-1:SQ_LO]);
        ss_q  <= 60'(sabs) * 60'(sabs);
        tn_q  <= 36'(rough_thr_q) * 36'(cell_q.count);
        span_ok_q <= span_diff > $signed(COORD_W'(span_thr_q));
      end
      S_E2: begin
        lhs_q <= (LHS_W'(phi_q) << SQ_LO) + LHS_W'(plo_q);
        tnn_q <= 52'(tn_q) * 52'(cell_q.count);
      end
      S_E3: begin
        res_obs_q <= span_ok_q && (lhs_q > rhs);
      end
      S_DONE: begin
        if (out_free) begin
          o_acc_q <= res_acc_q;
          o_obs_q <= res_obs_q;
          o_cnt_q <= res_cnt_q;
          o_lo_q  <= res_lo_q;
          o_hi_q  <= res_hi_q;
        end
      end
      default: ;
    endcase
  end

  // a transfer in is always followed by item_in not ready
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_in.valid && item_in.ready |=> !item_in.ready)
    else $error("second item taken while one is in work");

  // a new result only comes out of the final state
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_out.valid) |-> $past(state_q == S_DONE))
    else $error("result shown without passing the final state");

  // no item during the clearing pass
  a_clear_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CLEAR |-> !item_in.ready && !ram_re)
    else $error("item or read during the clearing pass");

  // an add is written back only when it was binned inside the grid
  a_add_wr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_MOD && op_q == OP_ADD |-> keep_q && cell_ok_q)
    else $error("dropped point reached the write back");

endmodule
